// ===== src/mdet_pkg.sv =====
package mdet_pkg;

	localparam int MAX_SIZE = 4;
	localparam int DEPTH = MAX_SIZE * MAX_SIZE;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int SIZE_W = 3;
	localparam int ELEM_W = 12;
	localparam int ACC_W = 80;
	localparam int OUT_W = 64;

endpackage

// ===== src/matrix_determinant.sv =====
// Exact determinant of an n x n signed 12-bit matrix, n = matrix_size (0 reads as 1,
// values above MAX_SIZE read as MAX_SIZE). Elements arrive one per start transaction
// in row-major order and are written into an element memory; busy stays low while
// loading. After the last element busy rises and the block evaluates the permutation
// expansion of the determinant. Each term is built factor by factor with one memory
// read per cycle. For each permutation the block issues one read per row, takes the
// last read data from the registered read port, and then adds the term into the
// running sum; busy stays high until the last term has been added. done is high
// for exactly one cycle, in the first cycle after busy falls, and the result is
// on det_value and saturated from that cycle. The receiver cannot stall it, so it
// must take the transaction in that cycle. Writing matrix_size while busy is low
// restarts loading; a write while busy is high is ignored. The result saturates to
// signed 64 bits and saturated flags it. The Laplace expansion with alternating signs
// equals the sum over permutations of sign * product, which is what is evaluated here.
module matrix_determinant (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [mdet_pkg::SIZE_W-1:0]        cfg_wdata,
	input  logic                               start,
	output logic                               busy,
	input  logic signed [mdet_pkg::ELEM_W-1:0] element_value,
	output logic                               done,
	output logic signed [mdet_pkg::OUT_W-1:0]  det_value,
	output logic                               saturated
);

	localparam int AW = mdet_pkg::ADDR_W;
	localparam int CW = $clog2(mdet_pkg::MAX_SIZE);
	localparam int MAXN = mdet_pkg::MAX_SIZE;
	localparam int PW = mdet_pkg::ACC_W;
	localparam int SIZE_W_L = mdet_pkg::SIZE_W;
	localparam int OUT_L = mdet_pkg::OUT_W;
	// A product of up to MAX_SIZE elements always fits this width.
	localparam int PRW = mdet_pkg::ELEM_W * mdet_pkg::MAX_SIZE;

	localparam logic [1:0] ST_LOAD = 2'd0;
	localparam logic [1:0] ST_RUN  = 2'd1;
	localparam logic [1:0] ST_FIN  = 2'd2;

	logic signed [mdet_pkg::ELEM_W-1:0] mem [mdet_pkg::DEPTH];
	logic signed [mdet_pkg::ELEM_W-1:0] rd_q;
	logic [AW-1:0] rd_addr;

	logic [1:0]         state_q;
	logic [SIZE_W_L-1:0] size_q;
	logic [AW:0]        cnt_q;
	logic [CW:0]        n_eff;
	logic [AW:0]        last_idx;

	// Permutation held as a column per row; row counter walks the product.
	logic [CW-1:0]      perm_q [MAXN];
	logic               par_q;
	logic [CW:0]        row_q;
	logic               rdv_q;
	logic [CW:0]        mrow_q;
	logic signed [PRW-1:0] prod_q;
	logic signed [PW-1:0] acc_q;
	logic               last_perm_q;

	logic signed [PRW-1:0] mul_w;
	logic [CW-1:0]      nxt_perm [MAXN];
	logic               nxt_par;
	logic               is_last;

	always_comb begin
		if (size_q == '0) begin
			n_eff = (CW+1)'(1);
		end else if (int'(size_q) > MAXN) begin
			n_eff = (CW+1)'(MAXN);
		end else begin
			n_eff = (CW+1)'(size_q);
		end
		last_idx = (AW+1)'(n_eff) * (AW+1)'(n_eff) - (AW+1)'(1);
	end

	// Next permutation in lexicographic order over the first n_eff places; the
	// parity flips on each swap. Reversal of the suffix uses up to MAXN / 2 swaps.
	always_comb begin
		logic [CW:0] i, j;
		logic found;
		logic [CW-1:0] t;
		logic [CW:0] lo, hi;
		for (int k = 0; k < MAXN; k++) begin
			nxt_perm[k] = perm_q[k];
		end
		nxt_par = par_q;
		i = '0;
		j = '0;
		t = '0;
		lo = '0;
		hi = '0;
		found = 1'b0;
		for (int k = 0; k < MAXN - 1; k++) begin
			if ((k + 1) < int'(n_eff) && perm_q[k] < perm_q[k + 1]) begin
				i = (CW+1)'(k);
				found = 1'b1;
			end
		end
		is_last = !found;
		if (found) begin
			for (int k = 0; k < MAXN; k++) begin
				if (k < int'(n_eff) && k > int'(i) && perm_q[k] > perm_q[i[CW-1:0]]) begin
					j = (CW+1)'(k);
				end
			end
			t = nxt_perm[i[CW-1:0]];
			nxt_perm[i[CW-1:0]] = nxt_perm[j[CW-1:0]];
			nxt_perm[j[CW-1:0]] = t;
			nxt_par = ~nxt_par;
			lo = i + (CW+1)'(1);
			hi = n_eff - (CW+1)'(1);
			for (int k = 0; k < MAXN / 2; k++) begin
				if (lo < hi) begin
					t = nxt_perm[lo[CW-1:0]];
					nxt_perm[lo[CW-1:0]] = nxt_perm[hi[CW-1:0]];
					nxt_perm[hi[CW-1:0]] = t;
					nxt_par = ~nxt_par;
					lo = lo + (CW+1)'(1);
					hi = hi - (CW+1)'(1);
				end
			end
		end
	end

	always_comb begin
		if (state_q == ST_LOAD) begin
			rd_addr = cnt_q[AW-1:0];
		end else begin
			rd_addr = AW'((AW+1)'(row_q) * (AW+1)'(n_eff) + (AW+1)'(perm_q[row_q[CW-1:0]]));
		end
	end

	// Element memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && start) begin
			mem[cnt_q[AW-1:0]] <= element_value;
		end
		rd_q <= mem[rd_addr];
	end

	assign mul_w = prod_q * PRW'(rd_q);
	assign busy = (state_q != ST_LOAD);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			size_q <= SIZE_W_L'(4);
			cnt_q <= '0;
			row_q <= '0;
			rdv_q <= 1'b0;
			mrow_q <= '0;
			done <= 1'b0;
			par_q <= 1'b0;
			last_perm_q <= 1'b0;
			for (int k = 0; k < MAXN; k++) begin
				perm_q[k] <= CW'(k);
			end
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_LOAD: begin
					if (cfg_we) begin
						size_q <= cfg_wdata;
						cnt_q <= '0;
					end else if (start) begin
						if (cnt_q == last_idx) begin
							cnt_q <= '0;
							state_q <= ST_RUN;
							row_q <= '0;
							rdv_q <= 1'b0;
							par_q <= 1'b0;
							last_perm_q <= 1'b0;
							for (int k = 0; k < MAXN; k++) begin
								perm_q[k] <= CW'(k);
							end
						end else begin
							cnt_q <= cnt_q + (AW+1)'(1);
						end
					end
				end
				ST_RUN: begin
					// Issue reads row by row; read data is registered and arrives in the following cycle.
					if (row_q < n_eff) begin
						row_q <= row_q + (CW+1)'(1);
						rdv_q <= 1'b1;
						mrow_q <= row_q;
					end else begin
						rdv_q <= 1'b0;
					end
					if (rdv_q && mrow_q == n_eff - (CW+1)'(1)) begin
						// Product of this permutation is complete next cycle.
						last_perm_q <= is_last;
						for (int k = 0; k < MAXN; k++) begin
							perm_q[k] <= nxt_perm[k];
						end
						par_q <= nxt_par;
						row_q <= '0;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					if (last_perm_q) begin
						done <= 1'b1;
						state_q <= ST_LOAD;
					end else begin
						state_q <= ST_RUN;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Datapath: product of the current term and the running sum.
	logic par_term_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && start && cnt_q == last_idx) begin
			acc_q <= '0;
		end
		if (state_q == ST_RUN) begin
			if (rdv_q) begin
				if (mrow_q == '0) begin
					prod_q <= PRW'(rd_q);
				end else begin
					prod_q <= mul_w;
				end
				if (mrow_q == n_eff - (CW+1)'(1)) begin
					par_term_q <= par_q;
				end
			end
		end
		if (state_q == ST_FIN) begin
			if (par_term_q) begin
				acc_q <= acc_q - PW'(prod_q);
			end else begin
				acc_q <= acc_q + PW'(prod_q);
			end
		end
	end

	// Saturate the final sum; it settles in the cycle done is high.
	logic signed [PW-1:0] fin_w;
	assign fin_w = acc_q;
	always_comb begin
		if (fin_w[PW-1:OUT_L-1] == '0 || fin_w[PW-1:OUT_L-1] == '1) begin
			det_value = fin_w[OUT_L-1:0];
			saturated = 1'b0;
		end else begin
			det_value = fin_w[PW-1] ? {1'b1, {(OUT_L-1){1'b0}}} : {1'b0, {(OUT_L-1){1'b1}}};
			saturated = 1'b1;
		end
	end

endmodule
